/* sv/fpln_pkg.sv */
// Shared types, widths and logarithm constants for the fixed-point natural log block.
// No dependencies; compile first.
`default_nettype none

package fpln_pkg;

    localparam int OPERAND_W = 31;
    localparam int RESULT_W  = 21;
    localparam int NORM_CELLS = 5;
    localparam int STEP_CELLS = 7;
    localparam int GAP_SHIFT  = 15;

    typedef logic        [OPERAND_W-1:0] operand_t;
    typedef logic signed [RESULT_W-1:0]  result_t;

    // One pipeline slot: mantissa being normalized/refined and running log
    typedef struct packed {
        operand_t x;
        result_t  y;
    } stage_t;

    // ln(32768) in signed 5.16 (21 bits, 16 fraction bits)
    localparam result_t LN_START = 21'sh0a65af;
    localparam logic [OPERAND_W:0] LN_TOP = 32'h8000_0000;

    // round(ln(1 + 2^-k) * 65536) for k = 1..7
    localparam result_t STEP_LN [STEP_CELLS] = '{
        21'sh067cd, 21'sh03920, 21'sh01e27, 21'sh00f85,
        21'sh007e1, 21'sh003f8, 21'sh001fe
    };

    // Multiple of ln2 matching a normalizing shift
    function automatic result_t ln_shift(input int shift);
        result_t val;
        begin
            val = '0;
            unique case (shift)
                16: val = 21'sh0b1721;
                8:  val = 21'sh058b91;
                4:  val = 21'sh02c5c8;
                2:  val = 21'sh0162e4;
                1:  val = 21'sh00b172;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/fpln_in_if.sv */
// Operand request channel: valid/ready handshake with the 31-bit operand.
// Depends on fpln_pkg.
`default_nettype none

interface fpln_in_if;
    import fpln_pkg::*;

    logic     valid;
    logic     ready;
    operand_t operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

`default_nettype wire

/* sv/fpln_out_if.sv */
// Result request channel: valid/ready handshake with the signed 5.16 (21-bit) log result.
// Depends on fpln_pkg.
`default_nettype none

interface fpln_out_if;
    import fpln_pkg::*;

    logic    valid;
    logic    ready;
    result_t log_result;

    modport source (output valid, output log_result, input ready);
    modport sink   (input valid, input log_result, output ready);
endinterface

`default_nettype wire

/* sv/fpln_norm_cell.sv */
// Normalizing cell: conditional left shift by SHIFT with the matching ln2 multiple.
// Depends on fpln_pkg.
`default_nettype none

module fpln_norm_cell #(
    parameter int SHIFT = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  wire                     valid_in,
    input  fpln_pkg::stage_t        stage_in,
    output logic                    valid_out,
    output fpln_pkg::stage_t        stage_out
);
    import fpln_pkg::*;

    localparam int      TOP_BIT = OPERAND_W - SHIFT;
    localparam result_t LN_SUB  = ln_shift(SHIFT);

    logic   take;
    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;

    // Shift when the top SHIFT bits are clear
    always_comb
    begin
        take = (stage_in.x[OPERAND_W-1:TOP_BIT] == '0);
        stage_next.x = take ? (stage_in.x << SHIFT) : stage_in.x;
        stage_next.y = take ? (stage_in.y - LN_SUB) : stage_in.y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

`default_nettype wire

/* sv/fpln_step_cell.sv */
// Refinement cell: multiply by (1 + 2^-K) when the product stays below 2^31.
// Depends on fpln_pkg.
`default_nettype none

module fpln_step_cell #(
    parameter int K = 1
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  wire                     valid_in,
    input  fpln_pkg::stage_t        stage_in,
    output logic                    valid_out,
    output fpln_pkg::stage_t        stage_out
);
    import fpln_pkg::*;

    localparam result_t LN_SUB = STEP_LN[K-1];

    logic [OPERAND_W:0] sum;
    logic               keep;
    logic               valid_reg;
    stage_t             stage_reg;
    stage_t             stage_next;

    always_comb
    begin
        sum  = {1'b0, stage_in.x} + {1'b0, (stage_in.x >> K)};
        keep = ~sum[OPERAND_W];
        stage_next.x = keep ? sum[OPERAND_W-1:0] : stage_in.x;
        stage_next.y = keep ? (stage_in.y - LN_SUB) : stage_in.y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

`default_nettype wire

/* sv/fixed_point_natural_log_top.sv */
// Pipeline from operand request to result: normalize cells, then refine cells, then the registered correction.
// Throughput: one operand per cycle unless stalled; each cell does a step and passes on.
// The whole chain advances together; a stalled result holds every stage in place.
// Reset (rst_n, async, active low) clears all valid bits; payload registers are not reset.
// Depends on fpln_pkg, fpln_in_if, fpln_out_if, fpln_norm_cell, fpln_step_cell.
`default_nettype none

module fixed_point_natural_log_top (
    input  wire          clk,
    input  wire          rst_n,
    fpln_in_if.sink      arg,
    fpln_out_if.source   res
);
    import fpln_pkg::*;

    localparam int CHAIN = NORM_CELLS + STEP_CELLS;

    // Slot 0 is the incoming request; slot CHAIN is the refined value
    logic   [CHAIN:0] valid_chain;
    stage_t           stage_chain [CHAIN+1];

    logic               advance;
    logic [OPERAND_W:0] gap;
    logic [OPERAND_W-GAP_SHIFT:0] corr;
    logic               res_valid_reg;
    result_t            result_reg;
    result_t            result_next;

    // Advance the chain whenever the output slot is free or being drained
    assign advance   = ~res_valid_reg | res.ready;
    assign arg.ready = advance;

    // Seed each request with ln(32768)
    assign valid_chain[0]   = arg.valid;
    assign stage_chain[0].x = arg.operand;
    assign stage_chain[0].y = LN_START;

    // Normalize into [2^30, 2^31) with shifts of 16, 8, 4, 2, 1
    for (genvar i = 0; i < NORM_CELLS; i++)
    begin : g_norm
        fpln_norm_cell #(
            .SHIFT (16 >> i)
        ) u_norm (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .valid_in  (valid_chain[i]),
            .stage_in  (stage_chain[i]),
            .valid_out (valid_chain[i+1]),
            .stage_out (stage_chain[i+1])
        );
    end

    // Refine with (1 + 2^-k), k = 1..7
    for (genvar j = 0; j < STEP_CELLS; j++)
    begin : g_step
        fpln_step_cell #(
            .K (j + 1)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .valid_in  (valid_chain[NORM_CELLS+j]),
            .stage_in  (stage_chain[NORM_CELLS+j]),
            .valid_out (valid_chain[NORM_CELLS+j+1]),
            .stage_out (stage_chain[NORM_CELLS+j+1])
        );
    end

    // Linear correction: subtract the remaining gap to 2^31, scaled down by 2^15
    always_comb
    begin
        gap  = LN_TOP - {1'b0, stage_chain[CHAIN].x};
        corr = gap[OPERAND_W:GAP_SHIFT];
        result_next = stage_chain[CHAIN].y
                    - result_t'({{(RESULT_W-(OPERAND_W-GAP_SHIFT+1)){1'b0}}, corr});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= valid_chain[CHAIN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.log_result = result_reg;

    // An accepted request lands in the first cell
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        arg.valid && arg.ready |=> valid_chain[1])
        else $error("accepted request missing from first cell");

    // A stalled chain holds every valid bit
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_chain[CHAIN:1]) && res.valid)
        else $error("chain moved while stalled");

    // After normalization the mantissa sits in [2^30, 2^31) or is zero
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        valid_chain[NORM_CELLS] |->
            stage_chain[NORM_CELLS].x[OPERAND_W-1] || (stage_chain[NORM_CELLS].x == '0))
        else $error("normalization left mantissa out of range");

    // The log never exceeds the start value
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.log_result <= LN_START)
        else $error("result above ln(32768)");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for fixed_point_natural_log_top: drives unsigned 15.16 operands with
// random gaps and result stalls, and checks every log against a local predictor.
// Depends on fpln_pkg, fpln_in_if, fpln_out_if and the block's RTL.
`timescale 1ns / 100ps

module testbench;
    import fpln_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 10;
    localparam int RAND_ITEMS  = 750;
    localparam int CALM_ITEMS  = 100;     // tail of the run with no idling on either side
    localparam int PIPE_DEPTH  = 13;      // register depth of the block's pipeline
    localparam int CYCLE_LIMIT = 200000;

    // Tracks outstanding log requests and grades the results as they come back.
    class log_tracker;
        localparam int LN_32768  = 'h0a65af;
        localparam int LN2_X16   = 'h0b1721;
        localparam int LN2_X8    = 'h058b91;
        localparam int LN2_X4    = 'h02c5c8;
        localparam int LN2_X2    = 'h0162e4;
        localparam int LN2_X1    = 'h00b172;

        result_t  pending_logs[$];
        operand_t pending_args[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // round(ln(1 + 2^-k) * 65536)
        function int refine_ln(int k);
            case (k)
                1:       return 'h067cd;
                2:       return 'h03920;
                3:       return 'h01e27;
                4:       return 'h00f85;
                5:       return 'h007e1;
                6:       return 'h003f8;
                default: return 'h001fe;
            endcase
        endfunction

        // Normalize into [2^30, 2^31), refine by (1 + 2^-k), then correct by the gap.
        function result_t predict_ln(operand_t a);
            logic [31:0] m;
            logic [32:0] sum;
            int          acc;
            m   = {1'b0, a};
            acc = LN_32768;
            if (m < 32'h0000_8000)
            begin
                m = m << 16;
                acc -= LN2_X16;
            end
            if (m < 32'h0080_0000)
            begin
                m = m << 8;
                acc -= LN2_X8;
            end
            if (m < 32'h0800_0000)
            begin
                m = m << 4;
                acc -= LN2_X4;
            end
            if (m < 32'h2000_0000)
            begin
                m = m << 2;
                acc -= LN2_X2;
            end
            if (m < 32'h4000_0000)
            begin
                m = m << 1;
                acc -= LN2_X1;
            end
            for (int k = 1; k <= 7; k++)
            begin
                sum = {1'b0, m} + {1'b0, m >> k};
                if (sum < 33'h0_8000_0000)
                begin
                    m = sum[31:0];
                    acc -= refine_ln(k);
                end
            end
            m = 32'h8000_0000 - m;
            acc -= int'(m >> 15);
            return result_t'(acc[20:0]);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        function void note_operand(operand_t a);
            pending_args.push_back(a);
            pending_logs.push_back(predict_ln(a));
        endfunction

        task check_log(result_t got);
            operand_t a;
            result_t  want;
            if (pending_logs.size() == 0)
            begin
                report($sformatf("log_result %0d with no request outstanding", got));
            end
            else
            begin
                a    = pending_args.pop_front();
                want = pending_logs.pop_front();
                if (got !== want)
                    report($sformatf("operand 0x%08h: log_result %0d, expected %0d",
                                     a, got, want));
            end
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    bit         calm;
    int         cycles;
    log_tracker tracker;

    fpln_in_if  arg_if ();
    fpln_out_if res_if ();

    fixed_point_natural_log_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .arg   (arg_if),
        .res   (res_if)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Hard stop: a hung handshake or lost result ends here.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drop valid and hold off for a span set by n.
    task automatic idle_sender(int n);
        arg_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Present one operand and hold it until the block takes the request.
    // Valid is left high so back-to-back requests need no extra assignment.
    task automatic push_operand(operand_t a);
        arg_if.valid   <= 1'b1;
        arg_if.operand <= a;
        do @(posedge clk); while (!arg_if.ready);
        tracker.note_operand(a);
    endtask

    // Drop valid and hold until every outstanding request has its result.
    task automatic pause_until_drained();
        arg_if.valid <= 1'b0;
        do @(posedge clk); while (tracker.pending_logs.size() != 0);
    endtask

    // Mix of uniform bit patterns, values of random magnitude (so every
    // normalizing shift combination shows up) and values hugging powers of two.
    function automatic operand_t rand_operand();
        int          span;
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:
            begin
                v = $urandom;
            end
            2:
            begin
                span = $urandom_range(0, 30);
                v    = (32'd1 << span) + $urandom_range(0, 15) - 8;
            end
            default:
            begin
                span = $urandom_range(1, 31);
                v    = ($urandom & ((32'd1 << span) - 1)) | (32'd1 << (span - 1));
            end
        endcase
        return v[30:0];
    endfunction

    // Result side: grade every accepted result, and stall ready in random bursts
    // except during the calm tail.
    initial
    begin : result_sink
        int stall;
        res_if.ready = 1'b0;
        stall        = 0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                tracker.check_log(res_if.log_result);
            if (stall > 0)
            begin
                stall--;
                if (stall == 0)
                    res_if.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall        = $urandom_range(1, 8);
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Operand side and end of run.
    initial
    begin : operand_source
        operand_t directed[$];
        tracker        = new();
        calm           = 1'b0;
        rst_n          = 1'b0;
        arg_if.valid   = 1'b0;
        arg_if.operand = '0;

        // Zero (runs the datapath with every shift and step taken), the
        // smallest and largest operands, 1.0, and both sides of each
        // normalizing threshold.
        directed = '{
            31'h0000_0000, 31'h0000_0001, 31'h0000_0002, 31'h0000_0003,
            31'h0000_7fff, 31'h0000_8000, 31'h0000_ffff, 31'h0001_0000,
            31'h0001_0001, 31'h007f_ffff, 31'h0080_0000, 31'h07ff_ffff,
            31'h0800_0000, 31'h1fff_ffff, 31'h2000_0000, 31'h3fff_ffff,
            31'h4000_0000, 31'h5555_5555, 31'h2aaa_aaaa, 31'h7fff_fffe,
            31'h7fff_ffff
        };

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            push_operand(directed[i]);

        // Let the pipe run dry once with nothing in flight.
        pause_until_drained();

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            calm = (i >= RAND_ITEMS - CALM_ITEMS);
            if (i == RAND_ITEMS / 2)
                pause_until_drained();
            else if (!calm && $urandom_range(0, 5) == 0)
                idle_sender($urandom_range(1, 8));
            push_operand(rand_operand());
        end
        arg_if.valid <= 1'b0;

        // Wait for the last results, then a little longer to catch strays.
        while (tracker.pending_logs.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_logs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
